// ===== rtl/core/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// Free list slot allocator package
// Shared constants, codes and types for the slot allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int unsigned POOL_SLOTS = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 9;

  localparam logic [CNT_W-1:0] POOL_SLOTS_CNT = CNT_W'(POOL_SLOTS);
  localparam logic [CNT_W-1:0] LIMIT_RESET    = CNT_W'(256);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] next;
    logic             tail;
  } link_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/core/fla_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot allocator controller
// Two-state sequencer that loads a request and then executes it.
// ----------------------------------------------------------------------------
module fla_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_strobe,
  output logic          cfg_ready,
  output fla_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic strobe_r;

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_EXEC);
    end
  end

  assign busy       = (state_r == ST_EXEC);
  assign cfg_ready  = (state_r == ST_IDLE) && !start;
  assign out_strobe = strobe_r;
  assign cmd.load   = start && (state_r == ST_IDLE);
  assign cmd.exec   = (state_r == ST_EXEC);

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("load not followed by execute");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_strobe) else $error("execute gave no result strobe");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.exec)) else $error("strobe without execute");

endmodule

// ===== rtl/core/fla_dp.sv =====
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Link store, free list head, high-water counter, limit register and result.
// ----------------------------------------------------------------------------
module fla_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fla_pkg::cmd_t              cmd,
  input  logic                       in_kind,
  input  logic [fla_pkg::IDX_W-1:0]  in_slot_index,
  input  logic                       cfg_we,
  input  logic [fla_pkg::CNT_W-1:0]  cfg_slot_limit,
  output logic [1:0]                 out_status,
  output logic [fla_pkg::IDX_W-1:0]  out_granted_index
);

  fla_pkg::link_t mem [fla_pkg::POOL_SLOTS];

  logic [fla_pkg::CNT_W-1:0] limit_r;
  logic                      head_valid_r;
  logic                      head_valid_nxt;
  logic [fla_pkg::IDX_W-1:0] head_idx_r;
  logic [fla_pkg::IDX_W-1:0] head_idx_nxt;
  logic [fla_pkg::CNT_W-1:0] hw_r;
  logic [fla_pkg::CNT_W-1:0] hw_nxt;
  logic                      kind_r;
  logic [fla_pkg::IDX_W-1:0] idx_r;
  fla_pkg::link_t            rd_data_r;
  logic [1:0]                status_r;
  logic [1:0]                status_nxt;
  logic [fla_pkg::IDX_W-1:0] granted_r;
  logic [fla_pkg::IDX_W-1:0] granted_nxt;

  logic [fla_pkg::IDX_W-1:0] rd_addr;
  logic                      mem_we;
  logic [fla_pkg::IDX_W-1:0] wr_addr;
  fla_pkg::link_t            wr_data;
  logic [fla_pkg::CNT_W-1:0] eff_limit;

  assign rd_addr   = (in_kind == fla_pkg::KIND_FREE) ? in_slot_index : head_idx_r;
  assign eff_limit = (limit_r > fla_pkg::POOL_SLOTS_CNT) ? fla_pkg::POOL_SLOTS_CNT : limit_r;

  always_comb begin
    head_valid_nxt = head_valid_r;
    head_idx_nxt   = head_idx_r;
    hw_nxt         = hw_r;
    status_nxt     = fla_pkg::STATUS_OK;
    granted_nxt    = '0;
    mem_we         = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{used: 1'b1, next: '0, tail: 1'b0};
    if (kind_r == fla_pkg::KIND_ALLOC) begin
      priority if (head_valid_r) begin
        granted_nxt    = head_idx_r;
        head_valid_nxt = !rd_data_r.tail;
        head_idx_nxt   = rd_data_r.tail ? '0 : rd_data_r.next;
        mem_we         = 1'b1;
        wr_addr        = head_idx_r;
      end else if (hw_r < eff_limit) begin
        granted_nxt = hw_r[fla_pkg::IDX_W-1:0];
        hw_nxt      = hw_r + 1'b1;
        mem_we      = 1'b1;
        wr_addr     = hw_r[fla_pkg::IDX_W-1:0];
      end else begin
        status_nxt = fla_pkg::STATUS_FULL;
      end
    end else begin
      if (({1'b0, idx_r} >= hw_r) || !rd_data_r.used) begin
        status_nxt = fla_pkg::STATUS_IGNORED;
      end else begin
        mem_we         = 1'b1;
        wr_addr        = idx_r;
        wr_data        = '{used: 1'b0,
                           next: head_valid_r ? head_idx_r : '0,
                           tail: !head_valid_r};
        head_valid_nxt = 1'b1;
        head_idx_nxt   = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= fla_pkg::LIMIT_RESET;
      head_valid_r <= 1'b0;
      head_idx_r   <= '0;
      hw_r         <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_slot_limit;
      end
      if (cmd.exec) begin
        head_valid_r <= head_valid_nxt;
        head_idx_r   <= head_idx_nxt;
        hw_r         <= hw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      idx_r  <= in_slot_index;
    end
    if (cmd.exec) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_granted_index = granted_r;

endmodule

// ===== rtl/core/free_list_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Free list slot allocator
// Hands out and takes back slots of a fixed pool through a LIFO free list.
//
// Channel  Ports                                   Transaction
// input    start, busy, in_kind, in_slot_index      start high while busy low
// result   out_strobe, out_status, out_granted_index one cycle, out_strobe high
// config   cfg_valid, cfg_ready, cfg_slot_limit     cfg_valid and cfg_ready high
//
// Each request takes two steps: a load that reads the link store, then an execute that updates it.
// Busy is high in the update cycle; the result shows in the cycle after it.
// A new request is taken while the previous result is on the ports.
// Reset is synchronous; the link store is not cleared and needs no sweep.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module free_list_slot_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [fla_pkg::IDX_W-1:0] in_slot_index,
  output logic                      out_strobe,
  output logic [1:0]                out_status,
  output logic [fla_pkg::IDX_W-1:0] out_granted_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fla_pkg::CNT_W-1:0] cfg_slot_limit
);

  fla_pkg::cmd_t cmd;

  fla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  fla_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_slot_index     (in_slot_index),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_slot_limit    (cfg_slot_limit),
    .out_status        (out_status),
    .out_granted_index (out_granted_index)
  );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate and free commands into the free list slot allocator and
// checks every result against a cycle-free model of the free list, the
// high-water counter and the slot limit. A directed opening covers the
// list corner cases; random phases under several limits follow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                      kind;
    logic [fla_pkg::IDX_W-1:0] slot_index;
  } req_t;

  typedef struct {
    logic [1:0]                status;
    logic [fla_pkg::IDX_W-1:0] granted;
  } grant_t;

  localparam int QUIET_LIMIT = 1000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_kind = fla_pkg::KIND_ALLOC;
  logic [fla_pkg::IDX_W-1:0] in_slot_index = '0;
  logic                      out_strobe;
  logic [1:0]                out_status;
  logic [fla_pkg::IDX_W-1:0] out_granted_index;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [fla_pkg::CNT_W-1:0] cfg_slot_limit = fla_pkg::LIMIT_RESET;

  req_t   request_q[$];
  grant_t grant_q[$];

  bit                      slot_held [fla_pkg::POOL_SLOTS];
  bit [fla_pkg::IDX_W-1:0] link_next [fla_pkg::POOL_SLOTS];
  bit                      link_last [fla_pkg::POOL_SLOTS];
  bit                      list_valid;
  bit [fla_pkg::IDX_W-1:0] list_top;
  bit [fla_pkg::CNT_W-1:0] fresh_count;
  bit [fla_pkg::CNT_W-1:0] limit_reg = fla_pkg::LIMIT_RESET;

  bit     in_fire;
  bit     cfg_fire;
  int     gap_left;
  int     idle_pct;
  int     quiet_cycles;
  int     error_count;
  int     alloc_count;
  int     free_count;
  int     full_count;
  int     ignored_count;
  int     limit_writes;
  req_t   drive_req;
  grant_t want;

  free_list_slot_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_slot_index     (in_slot_index),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slot_limit    (cfg_slot_limit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic grant_t predict_grant(logic kind, logic [fla_pkg::IDX_W-1:0] idx);
    grant_t                    g;
    logic [fla_pkg::CNT_W-1:0] cap;
    logic [fla_pkg::IDX_W-1:0] s;
    g.status  = fla_pkg::STATUS_OK;
    g.granted = '0;
    cap = (limit_reg > fla_pkg::POOL_SLOTS_CNT) ? fla_pkg::POOL_SLOTS_CNT : limit_reg;
    if (kind == fla_pkg::KIND_ALLOC) begin
      if (list_valid) begin
        s = list_top;
        g.granted = s;
        list_valid = !link_last[s];
        list_top = link_last[s] ? '0 : link_next[s];
        slot_held[s] = 1'b1;
        link_next[s] = '0;
        link_last[s] = 1'b0;
      end else if (fresh_count < cap) begin
        s = fresh_count[fla_pkg::IDX_W-1:0];
        g.granted = s;
        fresh_count = fresh_count + 1'b1;
        slot_held[s] = 1'b1;
        link_next[s] = '0;
        link_last[s] = 1'b0;
      end else begin
        g.status = fla_pkg::STATUS_FULL;
      end
    end else if ({1'b0, idx} >= fresh_count || !slot_held[idx]) begin
      g.status = fla_pkg::STATUS_IGNORED;
    end else begin
      slot_held[idx] = 1'b0;
      link_last[idx] = !list_valid;
      link_next[idx] = list_valid ? list_top : '0;
      list_valid = 1'b1;
      list_top = idx;
    end
    return g;
  endfunction

  function automatic int pick_held_slot();
    int base;
    int s;
    base = $urandom_range(0, fla_pkg::POOL_SLOTS - 1);
    for (int i = 0; i < fla_pkg::POOL_SLOTS; i++) begin
      s = (base + i) % fla_pkg::POOL_SLOTS;
      if (slot_held[s]) return s;
    end
    return -1;
  endfunction

  // Driver: holds a command until it is taken, then idles for a burst if one was drawn.
  always @(negedge clk) begin
    if (!rst_n) begin
      start = 1'b0;
    end else if (!start || in_fire) begin
      if (gap_left == 0 && request_q.size() > 0) begin
        drive_req = request_q.pop_front();
        start = 1'b1;
        in_kind = drive_req.kind;
        in_slot_index = drive_req.slot_index;
        if ($urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 18);
      end else begin
        start = 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: checks results in order, predicts accepted commands and tracks the limit.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 1'b0;
      cfg_fire = 1'b0;
    end else begin
      if (out_strobe) begin
        if (grant_q.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d index %0d",
                   $time, out_status, out_granted_index);
          error_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            error_count++;
          end
          if (out_granted_index !== want.granted) begin
            $display("%0t: granted index expected %0d, got %0d",
                     $time, want.granted, out_granted_index);
            error_count++;
          end
        end
      end
      in_fire = start && !busy;
      if (in_fire) begin
        want = predict_grant(in_kind, in_slot_index);
        grant_q.push_back(want);
        if (in_kind == fla_pkg::KIND_ALLOC) alloc_count++;
        else free_count++;
        if (want.status == fla_pkg::STATUS_FULL) full_count++;
        if (want.status == fla_pkg::STATUS_IGNORED) ignored_count++;
      end
      cfg_fire = cfg_valid && cfg_ready;
      if (cfg_fire) begin
        limit_reg = cfg_slot_limit;
        limit_writes++;
      end
      if (in_fire || out_strobe || cfg_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_request(logic kind, logic [fla_pkg::IDX_W-1:0] idx);
    req_t r;
    r.kind = kind;
    r.slot_index = idx;
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_slot_limit(logic [fla_pkg::CNT_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_slot_limit <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic issue_random(int count, int alloc_pct);
    int held;
    for (int n = 0; n < count; n++) begin
      while (request_q.size() >= 2) @(negedge clk);
      if ($urandom_range(0, 99) < alloc_pct) begin
        push_request(fla_pkg::KIND_ALLOC, fla_pkg::IDX_W'($urandom));
      end else begin
        held = pick_held_slot();
        if (held >= 0 && $urandom_range(0, 3) != 0) begin
          push_request(fla_pkg::KIND_FREE, fla_pkg::IDX_W'(held));
        end else begin
          push_request(fla_pkg::KIND_FREE, fla_pkg::IDX_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Frees of never-used slots, fresh grants, double frees and list pops in LIFO order.
    push_request(fla_pkg::KIND_FREE, 8'd0);
    push_request(fla_pkg::KIND_FREE, 8'd255);
    push_request(fla_pkg::KIND_ALLOC, 8'd255);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_ALLOC, 8'd170);
    push_request(fla_pkg::KIND_ALLOC, 8'd85);
    push_request(fla_pkg::KIND_FREE, 8'd1);
    push_request(fla_pkg::KIND_FREE, 8'd1);
    push_request(fla_pkg::KIND_FREE, 8'd3);
    push_request(fla_pkg::KIND_FREE, 8'd200);
    push_request(fla_pkg::KIND_FREE, 8'd4);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_FREE, 8'd0);
    push_request(fla_pkg::KIND_FREE, 8'd2);
    push_request(fla_pkg::KIND_FREE, 8'd4);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_FREE, 8'd4);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_ALLOC, 8'd0);
    push_request(fla_pkg::KIND_FREE, 8'd5);
    push_request(fla_pkg::KIND_FREE, 8'd5);

    idle_pct = 20;
    write_slot_limit(9'd3);
    issue_random(50, 55);
    write_slot_limit(9'd0);
    issue_random(50, 50);
    idle_pct = 0;
    write_slot_limit(9'd1);
    issue_random(30, 60);
    idle_pct = 25;
    write_slot_limit(9'd257);
    issue_random(70, 50);
    write_slot_limit(9'd20);
    issue_random(60, 65);
    idle_pct = 10;
    write_slot_limit(9'd256);
    issue_random(200, 95);
    write_slot_limit(9'd511);
    issue_random(100, 90);
    idle_pct = 0;
    issue_random(60, 50);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Covered %0d commands (%0d allocates, %0d frees) across %0d limit writes.",
             alloc_count + free_count, alloc_count, free_count, limit_writes);
    $display("Saw %0d pool-full and %0d ignored-free results; high-water mark %0d of %0d.",
             full_count, ignored_count, fresh_count, fla_pkg::POOL_SLOTS);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
